[sv/hsv_pixel_color_grade_defines.svh]
// ---------------------------------------------------------------------------
// hsv_pixel_color_grade_defines
// Assertion macros shared by the color grade RTL.
// ---------------------------------------------------------------------------
`ifndef HSV_PIXEL_COLOR_GRADE_DEFINES_SVH
`define HSV_PIXEL_COLOR_GRADE_DEFINES_SVH

`ifndef SYNTHESIS
// checked property, held off while reset is asserted
`define HPCG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hpcg assertion failed");
// checked property, also active during reset
`define HPCG_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("hpcg assertion failed");
`else
`define HPCG_ASSERT(lbl, clk, rst_n, prop)
`define HPCG_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[sv/hpcg_pkg.sv]
// ---------------------------------------------------------------------------
// hpcg_pkg
// Types, constants and helper functions of the HSV color grade pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package hpcg_pkg;

    // fixed point: hue in 1/64 degree, s and v in Q.16
    localparam int UNITY      = 65536;
    localparam int HUE_FULL   = 23040;
    localparam int HUE_SIXTH  = 3840;
    localparam int HUE_THIRD  = 7680;
    localparam int HUE_2THIRD = 15360;

    // factor caps (excess over 1.0)
    localparam int SAT_EXTRA_CAP = 131072;
    localparam int BRI_EXTRA_CAP = 65536;

    // value = ceil(mx * 65536 / 255) = 257 * mx + (mx != 0)
    localparam int VAL_SCALE = 257;

    // reciprocals: floor(2^17 / 45) and floor(2^24 / 15)
    localparam int RECIP_45 = 2912;
    localparam int RECIP_15 = 1118481;

    // divider: 9-bit remainder over a 24-bit dividend/quotient
    localparam int DIV_W      = 24;
    localparam int DIV_ACC_W  = 33;
    localparam int DIV_STAGES = 6;

    typedef enum logic [2:0] {
        CFG_BASS   = 3'd0,
        CFG_MID    = 3'd1,
        CFG_TREBLE = 3'd2,
        CFG_BEAT   = 3'd3,
        CFG_SAT    = 3'd4,
        CFG_BRI    = 3'd5,
        CFG_HUE    = 3'd6,
        CFG_FLASH  = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        SECT_RED_YEL  = 3'd0,
        SECT_YEL_GRN  = 3'd1,
        SECT_GRN_CYN  = 3'd2,
        SECT_CYN_BLU  = 3'd3,
        SECT_BLU_MAG  = 3'd4,
        SECT_MAG_RED  = 3'd5
    } t_sector;

    // one request inside the divider stages
    typedef struct packed {
        logic [DIV_ACC_W-1:0] hacc;
        logic [DIV_ACC_W-1:0] sacc;
        logic [7:0]           d;
        logic [7:0]           mx;
        logic [16:0]          v;
        logic [7:0]           alpha;
        logic                 fe;
        logic                 d0;
        logic                 mx0;
    } t_div_stage;

    // four restoring division steps: remainder in the top 9 bits,
    // dividend shifts out of the low bits as quotient bits shift in
    function automatic logic [DIV_ACC_W-1:0] div_step4(
        input logic [DIV_ACC_W-1:0] acc,
        input logic [7:0]           dv
    );
        logic [DIV_ACC_W-1:0] a;
        a = acc;
        for (int i = 0; i < 4; i++) begin
            a = {a[DIV_ACC_W-2:0], 1'b0};
            if (a[DIV_ACC_W-1:DIV_W] >= {1'b0, dv}) begin
                a[DIV_ACC_W-1:DIV_W] = a[DIV_ACC_W-1:DIV_W] - {1'b0, dv};
                a[0] = 1'b1;
            end
        end
        return a;
    endfunction

endpackage

`default_nettype wire

[sv/hsv_pixel_color_grade.sv]
// Pipeline: 15 register stages. Throughput: one pixel per cycle while the output
// is not stalled, set by the fully pipelined datapath (six 4-bit divider stages,
// constant divides by reciprocal multiply). A configuration write reaches the
// derived factors through their own register stages.
// Reset (synchronous, active low) clears all valid bits and loads the
// register defaults; payload registers are not reset.
// ---------------------------------------------------------------------------
// hsv_pixel_color_grade
// Audio driven HSV color grade of one RGBA pixel per clock while the output is not stalled.
// ---------------------------------------------------------------------------
`default_nettype none

`include "hsv_pixel_color_grade_defines.svh"

module hsv_pixel_color_grade
    import hpcg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_wdata,
    // pixel in
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_red_in,
    input  wire logic [7:0]  i_green_in,
    input  wire logic [7:0]  i_blue_in,
    input  wire logic [7:0]  i_alpha_in,
    input  wire logic        i_frame_end_in,
    // pixel out
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_red_out,
    output logic [7:0]       o_green_out,
    output logic [7:0]       o_blue_out,
    output logic [7:0]       o_alpha_out,
    output logic             o_frame_end_out
);

    localparam int NSTG = 15;

    // ---------------- configuration registers ----------------
    logic [15:0] r_bass, r_mid, r_treble, r_sat_resp, r_bri_resp, r_hue_resp, r_flash;
    logic        r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bass     <= 16'd0;
            r_mid      <= 16'd0;
            r_treble   <= 16'd0;
            r_beat     <= 1'b0;
            r_sat_resp <= 16'd512;
            r_bri_resp <= 16'd384;
            r_hue_resp <= 16'd3840;
            r_flash    <= 16'd19661;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BASS:   r_bass     <= i_cfg_wdata;
                CFG_MID:    r_mid      <= i_cfg_wdata;
                CFG_TREBLE: r_treble   <= i_cfg_wdata;
                CFG_BEAT:   r_beat     <= i_cfg_wdata[0];
                CFG_SAT:    r_sat_resp <= i_cfg_wdata;
                CFG_BRI:    r_bri_resp <= i_cfg_wdata;
                CFG_HUE:    r_hue_resp <= i_cfg_wdata;
                CFG_FLASH:  r_flash    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- derived factors (4 stages) ----------------
    logic [31:0] r_sat_p, r_bri_p, r_hue_p;
    logic [17:0] r_sat_mult, r_bri_mult;
    logic [20:0] r_hue_x, r_hue_x2;
    logic [6:0]  r_hue_q;
    logic [14:0] r_shift;

    logic [35:0] n_sat_x10;
    logic [27:0] n_sat_x;
    logic [26:0] n_bri_x;
    logic [36:0] n_hue_x20;
    logic [11:0] n_hue_y;
    logic [23:0] n_hue_qk;
    logic [21:0] n_hue_r;

    always_comb begin
        n_sat_x10 = (36'(r_sat_p) << 3) + (36'(r_sat_p) << 1);
        n_sat_x   = n_sat_x10[35:8];
        n_bri_x   = r_bri_p[31:5];
        n_hue_x20 = (37'(r_hue_p) << 4) + (37'(r_hue_p) << 2);
        n_hue_y   = r_hue_x[20:9];
        n_hue_qk  = 24'(n_hue_y) * 24'(RECIP_45);
        // quotient may be one low: one correction
        n_hue_r   = 22'(r_hue_x2) - 22'(r_hue_q) * 22'(HUE_FULL);
        if (n_hue_r >= 22'(HUE_FULL)) begin
            n_hue_r = n_hue_r - 22'(HUE_FULL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat_p    <= '0;
            r_bri_p    <= '0;
            r_hue_p    <= '0;
            r_sat_mult <= '0;
            r_bri_mult <= '0;
            r_hue_x    <= '0;
            r_hue_x2   <= '0;
            r_hue_q    <= '0;
            r_shift    <= '0;
        end else begin
            r_sat_p <= 32'(r_bass) * 32'(r_sat_resp);
            r_bri_p <= 32'(r_treble) * 32'(r_bri_resp);
            r_hue_p <= 32'(r_mid) * 32'(r_hue_resp);
            r_sat_mult <= 18'(UNITY) + ((n_sat_x > 28'(SAT_EXTRA_CAP)) ?
                          18'(SAT_EXTRA_CAP) : n_sat_x[17:0]);
            r_bri_mult <= 18'(UNITY) + ((n_bri_x > 27'(BRI_EXTRA_CAP)) ?
                          18'(BRI_EXTRA_CAP) : n_bri_x[17:0]);
            r_hue_x  <= n_hue_x20[36:16];
            r_hue_x2 <= r_hue_x;
            r_hue_q  <= n_hue_qk[23:17];
            r_shift  <= n_hue_r[14:0];
        end
    end

    // ---------------- pipeline control ----------------
    logic [NSTG-1:0] r_vld;
    logic            en;

    assign en         = !(r_vld[NSTG-1] && i_out_stall);
    assign o_in_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_in_valid};
        end
    end

    // ---------------- stage 0: input register ----------------
    logic [7:0] r0_r, r0_g, r0_b, r0_a;
    logic       r0_fe;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_r  <= i_red_in;
            r0_g  <= i_green_in;
            r0_b  <= i_blue_in;
            r0_a  <= i_alpha_in;
            r0_fe <= i_frame_end_in;
        end
    end

    // ---------------- stage 1: max/min, hue numerator, value ----------------
    logic [7:0]  s1_mx, s1_mn, s1_d;
    logic [10:0] s1_k;
    logic [23:0] s1_num;
    logic [16:0] s1_v;

    always_comb begin
        s1_mx = (r0_r > r0_g) ? ((r0_r > r0_b) ? r0_r : r0_b)
                              : ((r0_g > r0_b) ? r0_g : r0_b);
        s1_mn = (r0_r < r0_g) ? ((r0_r < r0_b) ? r0_r : r0_b)
                              : ((r0_g < r0_b) ? r0_g : r0_b);
        s1_d  = s1_mx - s1_mn;
        // numerator in sixths: red first, then green, then blue
        if (s1_mx == r0_r) begin
            if (r0_g >= r0_b) begin
                s1_k = {3'd0, r0_g} - {3'd0, r0_b};
            end else begin
                s1_k = ({3'd0, s1_d} << 2) + ({3'd0, s1_d} << 1)
                       - ({3'd0, r0_b} - {3'd0, r0_g});
            end
        end else if (s1_mx == r0_g) begin
            s1_k = {3'd0, r0_b} + ({3'd0, s1_d} << 1) - {3'd0, r0_r};
        end else begin
            s1_k = {3'd0, r0_r} + ({3'd0, s1_d} << 2) - {3'd0, r0_g};
        end
        s1_num = 24'(s1_k) * 24'(HUE_SIXTH);
        s1_v   = 17'(s1_mx) * 17'(VAL_SCALE) + {16'd0, (s1_mx != 8'd0)};
    end

    // ---------------- stages 1..7: hue and saturation dividers ----------------
    t_div_stage r_dv [0:DIV_STAGES];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv[0].hacc  <= {9'd0, s1_num};
            r_dv[0].sacc  <= {9'd0, s1_d, 16'd0};
            r_dv[0].d     <= s1_d;
            r_dv[0].mx    <= s1_mx;
            r_dv[0].v     <= s1_v;
            r_dv[0].alpha <= r0_a;
            r_dv[0].fe    <= r0_fe;
            r_dv[0].d0    <= (s1_d == 8'd0);
            r_dv[0].mx0   <= (s1_mx == 8'd0);
            for (int j = 1; j <= DIV_STAGES; j++) begin
                r_dv[j].hacc  <= div_step4(r_dv[j-1].hacc, r_dv[j-1].d);
                r_dv[j].sacc  <= div_step4(r_dv[j-1].sacc, r_dv[j-1].mx);
                r_dv[j].d     <= r_dv[j-1].d;
                r_dv[j].mx    <= r_dv[j-1].mx;
                r_dv[j].v     <= r_dv[j-1].v;
                r_dv[j].alpha <= r_dv[j-1].alpha;
                r_dv[j].fe    <= r_dv[j-1].fe;
                r_dv[j].d0    <= r_dv[j-1].d0;
                r_dv[j].mx0   <= r_dv[j-1].mx0;
            end
        end
    end

    // ---------------- stage 8: hue rotate, s/v products ----------------
    logic [14:0] s8_h0;
    logic [15:0] s8_hs;
    logic [16:0] s8_s;
    logic [14:0] r8_h;
    logic [34:0] r8_sp, r8_vp;
    logic [7:0]  r8_a;
    logic        r8_fe;

    always_comb begin
        s8_h0 = r_dv[DIV_STAGES].d0 ? 15'd0 : r_dv[DIV_STAGES].hacc[14:0];
        s8_hs = 16'(s8_h0) + 16'(r_shift);
        if (s8_hs >= 16'(HUE_FULL)) begin
            s8_hs = s8_hs - 16'(HUE_FULL);
        end
        s8_s = r_dv[DIV_STAGES].mx0 ? 17'd0 : r_dv[DIV_STAGES].sacc[16:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_h  <= s8_hs[14:0];
            r8_sp <= 35'(s8_s) * 35'(r_sat_mult);
            r8_vp <= 35'(r_dv[DIV_STAGES].v) * 35'(r_bri_mult);
            r8_a  <= r_dv[DIV_STAGES].alpha;
            r8_fe <= r_dv[DIV_STAGES].fe;
        end
    end

    // ---------------- stage 9: flash and clamp ----------------
    logic [18:0] s9_sv, s9_vv;
    logic [14:0] r9_h;
    logic [16:0] r9_s, r9_v;
    logic [7:0]  r9_a;
    logic        r9_fe;

    always_comb begin
        s9_sv = r8_sp[34:16];
        s9_vv = r8_vp[34:16] + (r_beat ? 19'(r_flash) : 19'd0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_h  <= r8_h;
            r9_s  <= (s9_sv > 19'(UNITY)) ? 17'(UNITY) : s9_sv[16:0];
            r9_v  <= (s9_vv > 19'(UNITY)) ? 17'(UNITY) : s9_vv[16:0];
            r9_a  <= r8_a;
            r9_fe <= r8_fe;
        end
    end

    // ---------------- stage 10: chroma, sector, ramp weight ----------------
    logic [33:0] s10_cp;
    logic [14:0] s10_t;
    logic [12:0] s10_dist;
    t_sector     s10_sect;
    logic [16:0] r10_c, r10_v;
    logic [11:0] r10_w;
    t_sector     r10_sect;
    logic [7:0]  r10_a;
    logic        r10_fe;

    always_comb begin
        s10_cp = 34'(r9_v) * 34'(r9_s);
        if (r9_h >= 15'(HUE_2THIRD)) begin
            s10_t = r9_h - 15'(HUE_2THIRD);
        end else if (r9_h >= 15'(HUE_THIRD)) begin
            s10_t = r9_h - 15'(HUE_THIRD);
        end else begin
            s10_t = r9_h;
        end
        s10_dist = (s10_t >= 15'(HUE_SIXTH)) ? 13'(s10_t - 15'(HUE_SIXTH))
                                             : 13'(15'(HUE_SIXTH) - s10_t);
        if (r9_h < 15'(HUE_SIXTH)) begin
            s10_sect = SECT_RED_YEL;
        end else if (r9_h < 15'(HUE_THIRD)) begin
            s10_sect = SECT_YEL_GRN;
        end else if (r9_h < 15'(3 * HUE_SIXTH)) begin
            s10_sect = SECT_GRN_CYN;
        end else if (r9_h < 15'(HUE_2THIRD)) begin
            s10_sect = SECT_CYN_BLU;
        end else if (r9_h < 15'(5 * HUE_SIXTH)) begin
            s10_sect = SECT_BLU_MAG;
        end else begin
            s10_sect = SECT_MAG_RED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_c    <= s10_cp[32:16];
            r10_v    <= r9_v;
            r10_w    <= 12'(13'(HUE_SIXTH) - s10_dist);
            r10_sect <= s10_sect;
            r10_a    <= r9_a;
            r10_fe   <= r9_fe;
        end
    end

    // ---------------- stage 11: c * weight ----------------
    logic [28:0] r11_p;
    logic [16:0] r11_c, r11_v;
    t_sector     r11_sect;
    logic [7:0]  r11_a;
    logic        r11_fe;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r11_p    <= 29'(r10_c) * 29'(r10_w);
            r11_c    <= r10_c;
            r11_v    <= r10_v;
            r11_sect <= r10_sect;
            r11_a    <= r10_a;
            r11_fe   <= r10_fe;
        end
    end

    // ---------------- stage 12: divide by 3840 (>>8, then reciprocal of 15) ----
    logic [19:0] s12_y;
    logic [40:0] s12_qk;
    logic [19:0] r12_y;
    logic [16:0] r12_q, r12_c, r12_v;
    t_sector     r12_sect;
    logic [7:0]  r12_a;
    logic        r12_fe;

    always_comb begin
        s12_y  = r11_p[27:8];
        s12_qk = 41'(s12_y) * 41'(RECIP_15);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r12_y    <= s12_y;
            r12_q    <= s12_qk[40:24];
            r12_c    <= r11_c;
            r12_v    <= r11_v;
            r12_sect <= r11_sect;
            r12_a    <= r11_a;
            r12_fe   <= r11_fe;
        end
    end

    // ---------------- stage 13: quotient correction ----------------
    logic [20:0] s13_rem;
    logic [16:0] r13_x, r13_c, r13_v;
    t_sector     r13_sect;
    logic [7:0]  r13_a;
    logic        r13_fe;

    assign s13_rem = 21'(r12_y) - 21'(r12_q) * 21'd15;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r13_x    <= (s13_rem >= 21'd15) ? r12_q + 17'd1 : r12_q;
            r13_c    <= r12_c;
            r13_v    <= r12_v;
            r13_sect <= r12_sect;
            r13_a    <= r12_a;
            r13_fe   <= r12_fe;
        end
    end

    // ---------------- stage 14: back to RGB, output register ----------------
    logic [16:0] s14_m, s14_rf, s14_gf, s14_bf;
    logic [16:0] s14_rs, s14_gs, s14_bs;
    logic [24:0] s14_rp, s14_gp, s14_bp;
    logic [7:0]  r14_r, r14_g, r14_b, r14_a;
    logic        r14_fe;

    always_comb begin
        s14_m = r13_v - r13_c;
        case (r13_sect)
            SECT_RED_YEL: begin s14_rf = r13_c; s14_gf = r13_x; s14_bf = '0;    end
            SECT_YEL_GRN: begin s14_rf = r13_x; s14_gf = r13_c; s14_bf = '0;    end
            SECT_GRN_CYN: begin s14_rf = '0;    s14_gf = r13_c; s14_bf = r13_x; end
            SECT_CYN_BLU: begin s14_rf = '0;    s14_gf = r13_x; s14_bf = r13_c; end
            SECT_BLU_MAG: begin s14_rf = r13_x; s14_gf = '0;    s14_bf = r13_c; end
            default:      begin s14_rf = r13_c; s14_gf = '0;    s14_bf = r13_x; end
        endcase
        s14_rs = s14_rf + s14_m;
        s14_gs = s14_gf + s14_m;
        s14_bs = s14_bf + s14_m;
        // x * 255 as (x << 8) - x
        s14_rp = (25'(s14_rs) << 8) - 25'(s14_rs);
        s14_gp = (25'(s14_gs) << 8) - 25'(s14_gs);
        s14_bp = (25'(s14_bs) << 8) - 25'(s14_bs);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r14_r  <= s14_rp[23:16];
            r14_g  <= s14_gp[23:16];
            r14_b  <= s14_bp[23:16];
            r14_a  <= r13_a;
            r14_fe <= r13_fe;
        end
    end

    assign o_out_valid     = r_vld[NSTG-1];
    assign o_red_out       = r14_r;
    assign o_green_out     = r14_g;
    assign o_blue_out      = r14_b;
    assign o_alpha_out     = r14_a;
    assign o_frame_end_out = r14_fe;

    // ---------------- assertions ----------------
    `HPCG_ASSERT(a_hue_quot_range, i_clk, i_rst_n, r_vld[7] && !r_dv[DIV_STAGES].d0 |-> r_dv[DIV_STAGES].hacc[23:0] < 24'(HUE_FULL))
    `HPCG_ASSERT(a_shift_range, i_clk, i_rst_n, r_shift < 15'(HUE_FULL))
    `HPCG_ASSERT(a_sv_clamped, i_clk, i_rst_n, r_vld[9] |-> (r9_s <= 17'(UNITY)) && (r9_v <= 17'(UNITY)))
    `HPCG_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

`default_nettype wire

[verif/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the HSV color grade pipeline: random and directed
// pixels under several register settings, compared against a fixed point
// prediction, with random idle on the input side and random stall on the output side.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
    import hpcg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       fe;
    } t_pixel;

    // expected graded pixels and the register copy they are predicted from
    class grade_scoreboard;
        t_pixel      graded_q[$];
        int unsigned bass, mid, treble, beat, sat_resp, bri_resp, hue_resp, flash;
        int          errors;

        function void reset_regs();
            bass = 0; mid = 0; treble = 0; beat = 0;
            sat_resp = 512; bri_resp = 384; hue_resp = 3840; flash = 19661;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [15:0] val);
            case (idx)
                CFG_BASS:   bass = val;
                CFG_MID:    mid = val;
                CFG_TREBLE: treble = val;
                CFG_BEAT:   beat = val[0];
                CFG_SAT:    sat_resp = val;
                CFG_BRI:    bri_resp = val;
                CFG_HUE:    hue_resp = val;
                CFG_FLASH:  flash = val;
                default:    ;
            endcase
        endfunction

        // grade one accepted pixel and queue the result
        function void note_pixel(t_pixel p);
            longint unsigned smul, bmul, shift, sv, vv;
            int unsigned r, g, b, h, s, v, mx, mn, d, num;
            int unsigned c, t, ramp_dist, x, m, rf, gf, bf, sector;
            t_pixel q;
            r = p.red; g = p.green; b = p.blue;
            smul = UNITY + ((longint'(bass) * sat_resp * 10) >> 8);
            if (smul > 3 * UNITY) smul = 3 * UNITY;
            bmul = UNITY + ((longint'(treble) * bri_resp * 8) >> 8);
            if (bmul > 2 * UNITY) bmul = 2 * UNITY;
            shift = ((longint'(mid) * hue_resp * 20) >> 16) % HUE_FULL;

            // RGB to HSV
            mx = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
            mn = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
            d = mx - mn;
            v = (mx * UNITY + 254) / 255;
            s = (mx == 0) ? 0 : (d * UNITY) / mx;
            if (d == 0) begin
                h = 0;
            end else begin
                if (mx == r)
                    num = (g >= b) ? HUE_SIXTH * (g - b)
                                   : HUE_FULL * d - HUE_SIXTH * (b - g);
                else if (mx == g)
                    num = HUE_SIXTH * (b + 2 * d - r);
                else
                    num = HUE_SIXTH * (r + 4 * d - g);
                h = (num / d) % HUE_FULL;
            end

            // grade
            h = 32'((h + shift) % HUE_FULL);
            sv = (longint'(s) * smul) >> 16;
            if (sv > UNITY) sv = UNITY;
            vv = (longint'(v) * bmul) >> 16;
            if (beat != 0) vv += flash;
            if (vv > UNITY) vv = UNITY;

            // HSV back to RGB, truncating
            c = 32'((vv * sv) >> 16);
            t = h % (2 * HUE_SIXTH);
            ramp_dist = (t >= HUE_SIXTH) ? t - HUE_SIXTH : HUE_SIXTH - t;
            x = (c * (HUE_SIXTH - ramp_dist)) / HUE_SIXTH;
            m = 32'(vv - c);
            sector = h / HUE_SIXTH;
            case (sector)
                SECT_RED_YEL: begin rf = c; gf = x; bf = 0; end
                SECT_YEL_GRN: begin rf = x; gf = c; bf = 0; end
                SECT_GRN_CYN: begin rf = 0; gf = c; bf = x; end
                SECT_CYN_BLU: begin rf = 0; gf = x; bf = c; end
                SECT_BLU_MAG: begin rf = x; gf = 0; bf = c; end
                default:      begin rf = c; gf = 0; bf = x; end
            endcase
            q.red   = 8'(((rf + m) * 255) >> 16);
            q.green = 8'(((gf + m) * 255) >> 16);
            q.blue  = 8'(((bf + m) * 255) >> 16);
            q.alpha = p.alpha;
            q.fe    = p.fe;
            graded_q.push_back(q);
        endfunction

        function void check_pixel(t_pixel got);
            t_pixel e;
            if (graded_q.size() == 0) begin
                $display("%0t: unexpected pixel r=%0d g=%0d b=%0d a=%0d fe=%0d",
                         $time, got.red, got.green, got.blue, got.alpha, got.fe);
                errors++;
                return;
            end
            e = graded_q.pop_front();
            if (got.red !== e.red) begin
                $display("%0t: red exp %0d got %0d", $time, e.red, got.red);
                errors++;
            end
            if (got.green !== e.green) begin
                $display("%0t: green exp %0d got %0d", $time, e.green, got.green);
                errors++;
            end
            if (got.blue !== e.blue) begin
                $display("%0t: blue exp %0d got %0d", $time, e.blue, got.blue);
                errors++;
            end
            if (got.alpha !== e.alpha) begin
                $display("%0t: alpha exp %0d got %0d", $time, e.alpha, got.alpha);
                errors++;
            end
            if (got.fe !== e.fe) begin
                $display("%0t: frame end exp %0d got %0d", $time, e.fe, got.fe);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_red_in = '0, i_green_in = '0, i_blue_in = '0, i_alpha_in = '0;
    logic        i_frame_end_in = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_red_out, o_green_out, o_blue_out, o_alpha_out;
    logic        o_frame_end_out;

    hsv_pixel_color_grade u_top (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    grade_scoreboard sb = new();
    int     idle_pct = 0;
    int     stall_pct = 0;
    int     quiet_cycles = 0;
    bit     in_take, out_take;
    t_pixel in_pix, out_pix;

    // handshake outcome sampled mid-cycle, when all inputs have settled
    always @(negedge i_clk) begin
        in_take  = i_rst_n && i_in_valid && !o_in_stall;
        out_take = i_rst_n && o_out_valid && !i_out_stall;
        in_pix   = '{i_red_in, i_green_in, i_blue_in, i_alpha_in, i_frame_end_in};
        out_pix  = '{o_red_out, o_green_out, o_blue_out, o_alpha_out, o_frame_end_out};
    end

    // accepted requests and results, receiver stall, watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_take) sb.note_pixel(in_pix);
            if (out_take) sb.check_pixel(out_pix);
            quiet_cycles = (in_take || out_take) ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= 5000) begin
                $display("TB_ERROR");
                $finish;
            end
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_pixel(logic [7:0] r, g, b, a, logic fe);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_red_in       <= r;
        i_green_in     <= g;
        i_blue_in      <= b;
        i_alpha_in     <= a;
        i_frame_end_in <= fe;
        do @(posedge i_clk); while (!in_take);
    endtask

    // sender goes quiet until the pipeline is empty
    task automatic drain();
        i_in_valid <= 1'b0;
        // let the last accepted request reach the scoreboard first
        @(negedge i_clk);
        while (sb.graded_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [15:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    // full register set, then time for the derived factors to settle
    task automatic load_regs(logic [15:0] bass, mid, treble, logic beat,
                             logic [15:0] sat, bri, hue, flash);
        cfg_write(CFG_BASS, bass);
        cfg_write(CFG_MID, mid);
        cfg_write(CFG_TREBLE, treble);
        cfg_write(CFG_BEAT, {15'd0, beat});
        cfg_write(CFG_SAT, sat);
        cfg_write(CFG_BRI, bri);
        cfg_write(CFG_HUE, hue);
        cfg_write(CFG_FLASH, flash);
        i_cfg_wr_en <= 1'b0;
        repeat (8) @(posedge i_clk);
    endtask

    task automatic send_random_pixel();
        logic [7:0] r, g, b;
        r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
        case ($urandom_range(5))
            0: begin g = r; b = r; end          // grey
            1: g = r;                           // red and green tie at max or min
            2: begin r = 8'd255; b = 8'd0; end  // saturated edge
            default: ;
        endcase
        send_pixel(r, g, b, 8'($urandom), 1'($urandom));
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            send_random_pixel();
            if (i == n / 2) drain();
        end
        drain();
    endtask

    initial begin
        sb.reset_regs();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: corners at reset defaults
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);        // black
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1); // white
        send_pixel(8'd128, 8'd128, 8'd128, 8'd7, 1'b0);   // grey
        send_pixel(8'd255, 8'd0, 8'd0, 8'd1, 1'b0);
        send_pixel(8'd0, 8'd255, 8'd0, 8'd2, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd255, 8'd3, 1'b0);
        send_pixel(8'd200, 8'd10, 8'd90, 8'd4, 1'b0);     // red max, green below blue
        send_pixel(8'd200, 8'd200, 8'd5, 8'd5, 1'b0);     // red and green tie
        send_pixel(8'd1, 8'd0, 8'd0, 8'd6, 1'b1);
        drain();

        // directed: every level and response at full scale, flash on
        load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
                  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd255, 1'b1);
        send_pixel(8'd255, 8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd30, 8'd60, 8'd90, 8'd9, 1'b0);
        send_pixel(8'd250, 8'd250, 8'd250, 8'd8, 1'b1);
        drain();

        // directed: everything zero
        load_regs(16'h0, 16'h0, 16'h0, 1'b0, 16'h0, 16'h0, 16'h0, 16'h0);
        send_pixel(8'd17, 8'd200, 8'd99, 8'd10, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd0, 8'd11, 1'b1);
        drain();

        // random phases across idle patterns and register settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 81; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 81; end
                default: begin idle_pct = 20; stall_pct = 20; end
            endcase
            if (ph == 4)
                load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0,
                          16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0);
            else
                load_regs(16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                          16'($urandom_range(1023)), 16'($urandom_range(1023)),
                          16'($urandom), 16'($urandom));
            random_phase(48);
        end
        idle_pct = 0;
        stall_pct = 0;
        drain();

        if (sb.errors == 0 && sb.graded_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

`default_nettype wire
